// File: hw/rtl/btpc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the barometric compensation block.
// No dependencies; imported by the channel interfaces and the top-level module.
package btpc_pkg;

  localparam int unsigned RawW    = 20;
  localparam int unsigned TempW   = 24;
  localparam int unsigned PressW  = 32;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DenW    = 31;
  localparam int unsigned QuoW    = 64;
  localparam int unsigned SideW   = TempW + 2;

  localparam logic [20:0] PressFull   = 21'd1048576;
  localparam logic [63:0] PressScale  = 64'd3125;
  localparam int unsigned OneShift    = 47;
  localparam int unsigned P1Shift     = 33;
  localparam int unsigned P4Shift     = 35;
  localparam int unsigned P5Shift     = 17;

  typedef enum logic [1:0] {
    RegTempP1 = 2'd0,
    RegP2P5   = 2'd1,
    RegP6P9   = 2'd2
  } reg_idx_e;

  // low 64 bits of a 64x64 product, split into three 32x32 partials
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] hl;
    logic [31:0] lh;
  } mul_parts_t;

  function automatic mul_parts_t mul_split(input logic [63:0] a, input logic [63:0] b);
    mul_parts_t r;
    r.ll = a[31:0] * b[31:0];
    r.hl = 32'(a[63:32] * b[31:0]);
    r.lh = 32'(a[31:0] * b[63:32]);
    return r;
  endfunction

  function automatic logic [63:0] mul_join(input mul_parts_t m);
    logic [31:0] hi;
    hi = m.hl + m.lh;
    return m.ll + {hi, 32'd0};
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
    return 64'($signed(x) >>> n);
  endfunction

endpackage

// File: hw/rtl/btpc_in_if.sv
`timescale 1ns / 1ps
// Input channel: one beat carries a raw temperature / pressure pair.
// Depends on btpc_pkg.
interface btpc_in_if import btpc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RawW-1:0] raw_temperature;
  logic [RawW-1:0] raw_pressure;

  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

// File: hw/rtl/btpc_out_if.sv
`timescale 1ns / 1ps
// Output channel: one beat carries compensated temperature and pressure.
// Depends on btpc_pkg.
interface btpc_out_if import btpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TempW-1:0]  temperature_centi;
  logic [PressW-1:0] pressure_q24_8;
  logic              pressure_valid;

  modport source (output valid, temperature_centi, pressure_q24_8, pressure_valid,
                  input ready);
  modport sink   (input valid, temperature_centi, pressure_q24_8, pressure_valid,
                  output ready);
endinterface

// File: hw/rtl/baro_temp_press_compensation.sv
`timescale 1ns / 1ps
// Barometric temperature / pressure compensation, fully pipelined.
// Depends on btpc_pkg, btpc_in_if, btpc_out_if and btpc_div.
//
// Usage:
//  - samp_i takes one raw temperature / pressure pair per beat; res_o gives
//    one result beat per input beat, in order.
//  - The twelve trim words sit in three 64-bit registers on the APB port at
//    byte offsets 0, 8 and 16; write them only while no beat is in flight.
//  - Throughput is one beat per cycle while the output buffer is not full.
//    A beat passes through 12 stages of temperature and trim arithmetic, a
//    64-stage divider (one quotient bit per stage), 6 stages of pressure
//    correction and the 2-entry output buffer.
//  - A zero pressure divisor yields pressure 0 with pressure_valid low;
//    temperature is still delivered.
//  - Reset clears the trim registers, all stage valid bits and the buffer.
//  - When res_o stalls, the buffer fills and the whole pipeline holds in
//    place; samp_i.ready drops only once both buffer entries are occupied.
module baro_temp_press_compensation
  import btpc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  btpc_in_if.sink           samp_i,
  btpc_out_if.source        res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  typedef struct packed {
    logic [TempW-1:0]  tc;
    logic [PressW-1:0] pr;
    logic              pv;
  } res_t;

  // ---------------- configuration ----------------
  logic [63:0] cfg_tp1_q, cfg_p25_q, cfg_p69_q;
  reg_idx_e    cfg_idx;
  logic        cfg_we;

  assign cfg_idx = reg_idx_e'(paddr[AddrW-1:3]);
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_tp1_q <= '0;
      cfg_p25_q <= '0;
      cfg_p69_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegTempP1: cfg_tp1_q <= pwdata;
        RegP2P5:   cfg_p25_q <= pwdata;
        RegP6P9:   cfg_p69_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegTempP1: prdata = cfg_tp1_q;
      RegP2P5:   prdata = cfg_p25_q;
      RegP6P9:   prdata = cfg_p69_q;
      default:   prdata = '0;
    endcase
  end

  logic [15:0] tr_t1, tr_p1, tr_p4, tr_p7, tr_p8, tr_p9;
  logic signed [15:0] t2_s, t3_s, p2_s, p3_s, p5_s, p6_s;

  assign tr_t1 = cfg_tp1_q[15:0];
  assign t2_s  = cfg_tp1_q[31:16];
  assign t3_s  = cfg_tp1_q[47:32];
  assign tr_p1 = cfg_tp1_q[63:48];
  assign p2_s  = cfg_p25_q[15:0];
  assign p3_s  = cfg_p25_q[31:16];
  assign tr_p4 = cfg_p25_q[47:32];
  assign p5_s  = cfg_p25_q[63:48];
  assign p6_s  = cfg_p69_q[15:0];
  assign tr_p7 = cfg_p69_q[31:16];
  assign tr_p8 = cfg_p69_q[47:32];
  assign tr_p9 = cfg_p69_q[63:48];

  // ---------------- flow control ----------------
  logic       adv;
  logic       in_acc;
  logic [1:0] fifo_cnt_q;

  assign adv          = (fifo_cnt_q != 2'd2);
  assign samp_i.ready = adv;
  assign in_acc       = samp_i.valid && adv;

  logic [11:0] pre_vld_q;
  logic [5:0]  post_vld_q;
  logic        div_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q  <= '0;
      post_vld_q <= '0;
    end else if (adv) begin
      pre_vld_q  <= {pre_vld_q[10:0], in_acc};
      post_vld_q <= {post_vld_q[4:0], div_vld};
    end
  end

  // ---------------- temperature ----------------
  logic signed [17:0] s1_a_d, s1_a_q;
  logic signed [16:0] s1_b_d, s1_b_q;
  logic [RawW-1:0]    ap_q [8];

  assign s1_a_d = {1'b0, samp_i.raw_temperature[RawW-1:3]} - {1'b0, tr_t1, 1'b0};
  assign s1_b_d = {1'b0, samp_i.raw_temperature[RawW-1:4]} - {1'b0, tr_t1};

  logic signed [33:0] s2_m1_d, s2_m1_q, s2_bb_d, s2_bb_q;
  assign s2_m1_d = s1_a_q * t2_s;
  assign s2_bb_d = s1_b_q * s1_b_q;

  logic signed [22:0] s3_v1_d, s3_v1_q;
  logic signed [21:0] s3_bbs;
  logic signed [37:0] s3_m2_d, s3_m2_q;
  assign s3_v1_d = 23'(s2_m1_q >>> 11);
  assign s3_bbs  = 22'(s2_bb_q >>> 12);
  assign s3_m2_d = s3_bbs * t3_s;

  logic signed [23:0] s4_v2t;
  logic signed [25:0] s4_tf_d, s4_tf_q;
  assign s4_v2t  = 24'(s3_m2_q >>> 14);
  assign s4_tf_d = 26'(s3_v1_q) + 26'(s4_v2t);

  logic signed [29:0] s5_tc5;
  logic [TempW-1:0]   s5_tc_d;
  logic signed [27:0] s5_vp_d, s5_vp_q;
  logic [TempW-1:0]   tc_q [8];
  assign s5_tc5  = 30'(s4_tf_q) * 30'sd5 + 30'sd128;
  assign s5_tc_d = 24'(s5_tc5 >>> 8);
  assign s5_vp_d = 28'(s4_tf_q) - 28'sd128000;

  // ---------------- pressure divisor and numerator ----------------
  logic signed [55:0] s6_sq_d, s6_sq_q;
  logic signed [43:0] s6_x5_d, s6_x5_q, s6_x2_d, s6_x2_q;
  assign s6_sq_d = s5_vp_q * s5_vp_q;
  assign s6_x5_d = s5_vp_q * p5_s;
  assign s6_x2_d = s5_vp_q * p2_s;

  logic signed [63:0] s7_y6_d, s7_y6_q, s7_y3_d, s7_y3_q;
  logic signed [43:0] s7_x5_q, s7_x2_q;
  assign s7_y6_d = s6_sq_q * p6_s;
  assign s7_y3_d = s6_sq_q * p3_s;

  logic [63:0] s8_v2_d, s8_v2_q, s8_w1_d, s8_w1_q;
  assign s8_v2_d = s7_y6_q + (64'(s7_x5_q) << P5Shift) + (sx16(tr_p4) << P4Shift);
  assign s8_w1_d = asr64(s7_y3_q, 8) + (64'(s7_x2_q) << 12);

  logic [20:0] s9_pp;
  logic [63:0] s9_w_d, s9_w_q, s9_n0_d, s9_n0_q;
  assign s9_pp   = PressFull - {1'b0, ap_q[7]};
  assign s9_w_d  = (64'd1 << OneShift) + s8_w1_q;
  assign s9_n0_d = {12'd0, s9_pp, 31'd0} - s8_v2_q;

  mul_parts_t s10_den_d, s10_den_q, s10_num_d, s10_num_q;
  assign s10_den_d = mul_split(s9_w_q, {48'd0, tr_p1});
  assign s10_num_d = mul_split(s9_n0_q, PressScale);

  logic [63:0]     s11_prod;
  logic [DenW-1:0] s11_den_d, s11_den_q;
  logic [63:0]     s11_num_d, s11_num_q;
  assign s11_prod  = mul_join(s10_den_q);
  assign s11_den_d = s11_prod[63:P1Shift];
  assign s11_num_d = mul_join(s10_num_q);

  logic [63:0]     s12_ma_d, s12_ma_q;
  logic [DenW-1:0] s12_mb_d, s12_mb_q;
  logic            s12_neg_d, s12_neg_q, s12_nz_d, s12_nz_q;
  assign s12_ma_d  = s11_num_q[63] ? (64'd0 - s11_num_q) : s11_num_q;
  assign s12_mb_d  = s11_den_q[DenW-1] ? (DenW'(0) - s11_den_q) : s11_den_q;
  assign s12_neg_d = s11_num_q[63] ^ s11_den_q[DenW-1];
  assign s12_nz_d  = (s11_den_q != '0);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_a_q    <= s1_a_d;
      s1_b_q    <= s1_b_d;
      ap_q[0]   <= samp_i.raw_pressure;
      for (int i = 1; i < 8; i++) begin
        ap_q[i] <= ap_q[i-1];
      end
      s2_m1_q   <= s2_m1_d;
      s2_bb_q   <= s2_bb_d;
      s3_v1_q   <= s3_v1_d;
      s3_m2_q   <= s3_m2_d;
      s4_tf_q   <= s4_tf_d;
      tc_q[0]   <= s5_tc_d;
      for (int i = 1; i < 8; i++) begin
        tc_q[i] <= tc_q[i-1];
      end
      s5_vp_q   <= s5_vp_d;
      s6_sq_q   <= s6_sq_d;
      s6_x5_q   <= s6_x5_d;
      s6_x2_q   <= s6_x2_d;
      s7_y6_q   <= s7_y6_d;
      s7_y3_q   <= s7_y3_d;
      s7_x5_q   <= s6_x5_q;
      s7_x2_q   <= s6_x2_q;
      s8_v2_q   <= s8_v2_d;
      s8_w1_q   <= s8_w1_d;
      s9_w_q    <= s9_w_d;
      s9_n0_q   <= s9_n0_d;
      s10_den_q <= s10_den_d;
      s10_num_q <= s10_num_d;
      s11_den_q <= s11_den_d;
      s11_num_q <= s11_num_d;
      s12_ma_q  <= s12_ma_d;
      s12_mb_q  <= s12_mb_d;
      s12_neg_q <= s12_neg_d;
      s12_nz_q  <= s12_nz_d;
    end
  end

  // ---------------- division ----------------
  logic [QuoW-1:0]  div_quo;
  logic [SideW-1:0] div_side;

  btpc_div #(
    .NumW  (QuoW),
    .DenW  (DenW),
    .SideW (SideW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (pre_vld_q[11]),
    .num_i   (s12_ma_q),
    .den_i   (s12_mb_q),
    .side_i  ({tc_q[7], s12_neg_q, s12_nz_q}),
    .valid_o (div_vld),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  // ---------------- pressure correction ----------------
  logic [TempW-1:0] etc_q [6];
  logic [5:0]       enz_q;

  logic [63:0] e1_p_d, e1_p_q;
  assign e1_p_d = div_side[1] ? (64'd0 - div_quo) : div_quo;

  logic [63:0] e2_qq_d, e2_qq_q, e2_p_q;
  mul_parts_t  e2_m8_d, e2_m8_q, e2_t9_d, e2_t9_q;
  assign e2_qq_d = asr64(e1_p_q, 13);
  assign e2_m8_d = mul_split(e1_p_q, sx16(tr_p8));
  assign e2_t9_d = mul_split(sx16(tr_p9), e2_qq_d);

  logic [63:0] e3_m8_d, e3_m8_q, e3_t9_d, e3_t9_q, e3_qq_q, e3_p_q;
  assign e3_m8_d = mul_join(e2_m8_q);
  assign e3_t9_d = mul_join(e2_t9_q);

  mul_parts_t  e4_y_d, e4_y_q;
  logic [63:0] e4_m8_q, e4_p_q;
  assign e4_y_d = mul_split(e3_t9_q, e3_qq_q);

  logic [63:0] e5_s_d, e5_s_q;
  assign e5_s_d = e4_p_q + asr64(mul_join(e4_y_q), 25) + asr64(e4_m8_q, 19);

  logic [63:0] e6_f_d, e6_f_q;
  assign e6_f_d = asr64(e5_s_q, 8) + (sx16(tr_p7) << 4);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      etc_q[0] <= div_side[SideW-1:2];
      for (int i = 1; i < 6; i++) begin
        etc_q[i] <= etc_q[i-1];
      end
      enz_q   <= {enz_q[4:0], div_side[0]};
      e1_p_q  <= e1_p_d;
      e2_qq_q <= e2_qq_d;
      e2_p_q  <= e1_p_q;
      e2_m8_q <= e2_m8_d;
      e2_t9_q <= e2_t9_d;
      e3_m8_q <= e3_m8_d;
      e3_t9_q <= e3_t9_d;
      e3_qq_q <= e2_qq_q;
      e3_p_q  <= e2_p_q;
      e4_y_q  <= e4_y_d;
      e4_m8_q <= e3_m8_q;
      e4_p_q  <= e3_p_q;
      e5_s_q  <= e5_s_d;
      e6_f_q  <= e6_f_d;
    end
  end

  // ---------------- saturation and output buffer ----------------
  res_t push_data;

  always_comb begin
    push_data.tc = etc_q[5];
    push_data.pv = enz_q[5];
    priority if (!enz_q[5]) begin
      push_data.pr = '0;
    end else if (e6_f_q[63]) begin
      push_data.pr = '0;
    end else if (e6_f_q[63:32] != '0) begin
      push_data.pr = '1;
    end else begin
      push_data.pr = e6_f_q[31:0];
    end
  end

  res_t fifo_q [2];
  logic fifo_wr_q, fifo_rd_q;
  logic push, pop;

  assign push = adv && post_vld_q[5];
  assign pop  = (fifo_cnt_q != 2'd0) && res_o.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[fifo_wr_q] <= push_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_wr_q  <= 1'b0;
      fifo_rd_q  <= 1'b0;
      fifo_cnt_q <= 2'd0;
    end else begin
      fifo_wr_q  <= fifo_wr_q ^ push;
      fifo_rd_q  <= fifo_rd_q ^ pop;
      fifo_cnt_q <= 2'(fifo_cnt_q + {1'b0, push} - {1'b0, pop});
    end
  end

  assign res_o.valid             = (fifo_cnt_q != 2'd0);
  assign res_o.temperature_centi = fifo_q[fifo_rd_q].tc;
  assign res_o.pressure_q24_8    = fifo_q[fifo_rd_q].pr;
  assign res_o.pressure_valid    = fifo_q[fifo_rd_q].pv;

endmodule

// File: hw/rtl/btpc_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// Sideband bits travel with each beat. No package dependencies.
module btpc_div #(
  parameter int unsigned NumW  = 64,
  parameter int unsigned DenW  = 31,
  parameter int unsigned SideW = 26
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [NumW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);

  logic [NumW-1:0]  vld_q;
  logic [NumW-1:0]  nq_q   [NumW];
  logic [DenW-1:0]  rem_q  [NumW];
  logic [DenW-1:0]  den_q  [NumW];
  logic [SideW-1:0] side_q [NumW];

  logic [NumW-1:0]  vld_in;
  logic [NumW-1:0]  nq_in   [NumW];
  logic [DenW-1:0]  rem_in  [NumW];
  logic [DenW-1:0]  den_in  [NumW];
  logic [SideW-1:0] side_in [NumW];

  genvar k;
  for (k = 0; k < NumW; k++) begin : g_stage
    logic [DenW:0]   trial;
    logic [DenW:0]   diff;
    logic            ge;
    logic [DenW-1:0] rem_d;
    logic [NumW-1:0] nq_d;

    if (k == 0) begin : g_first
      assign vld_in[k]  = valid_i;
      assign nq_in[k]   = num_i;
      assign rem_in[k]  = '0;
      assign den_in[k]  = den_i;
      assign side_in[k] = side_i;
    end else begin : g_next
      assign vld_in[k]  = vld_q[k-1];
      assign nq_in[k]   = nq_q[k-1];
      assign rem_in[k]  = rem_q[k-1];
      assign den_in[k]  = den_q[k-1];
      assign side_in[k] = side_q[k-1];
    end

    // shift in the next numerator bit, subtract if it fits
    assign trial = {rem_in[k], nq_in[k][NumW-1]};
    assign diff  = trial - {1'b0, den_in[k]};
    assign ge    = (trial >= {1'b0, den_in[k]});
    assign rem_d = ge ? diff[DenW-1:0] : trial[DenW-1:0];
    assign nq_d  = {nq_in[k][NumW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k]   <= nq_d;
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = vld_q[NumW-1];
  assign quo_o   = nq_q[NumW-1];
  assign side_o  = side_q[NumW-1];

endmodule
